>>> rtl/assert_macros.svh
// assertion macros used by the port checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, sampled on clk, off while rst is high
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> rtl/fbpa_pkg.sv
// types, constants and helpers of the block pool allocator
`timescale 1ns / 1ps
package fbpa_pkg;

  localparam int SLOTS           = 256;
  localparam int IDX_W           = $clog2(SLOTS);
  localparam int CAP_W           = 9;
  localparam int SIZE_W          = 13;
  localparam int OFS_W           = 20;
  localparam int MIN_BLOCK_BYTES = 8;
  localparam int MAX_BLOCK_BYTES = 4096;
  localparam int CFG_W           = 13;
  localparam int CFG_IDX_W       = 1;

  localparam logic [1:0] REQ_ALLOC  = 2'd0;
  localparam logic [1:0] REQ_ZALLOC = 2'd1;
  localparam logic [1:0] REQ_FREE   = 2'd2;
  localparam logic [1:0] REQ_RESET  = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [1:0] ST_INVALID   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEMBER_SIZE = 1'd1;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [OFS_W-1:0] slot_offset;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [OFS_W-1:0] block_offset;
    logic             clear_slot;
  } rsp_t;

  // one link entry: next freed block and whether it exists
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] head;
  } link_t;

  typedef struct packed {
    logic             done;
    logic             bad;
    logic [IDX_W-1:0] quot;
  } div_res_t;

  function automatic logic [SIZE_W-1:0] block_bytes(input logic [SIZE_W-1:0] member_size);
    logic [SIZE_W-1:0] b;
    b = member_size;
    if (b < SIZE_W'(MIN_BLOCK_BYTES)) b = SIZE_W'(MIN_BLOCK_BYTES);
    if (b > SIZE_W'(MAX_BLOCK_BYTES)) b = SIZE_W'(MAX_BLOCK_BYTES);
    return b;
  endfunction

  function automatic logic [CAP_W-1:0] eff_capacity(input logic [CAP_W-1:0] capacity);
    return (capacity > CAP_W'(SLOTS)) ? CAP_W'(SLOTS) : capacity;
  endfunction

endpackage

>>> rtl/fbpa_link_ram.sv
// link store: one next-pointer per freed block, synchronous read
`timescale 1ns / 1ps
module fbpa_link_ram
  import fbpa_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  link_t            wdata,
  input  logic             re,
  input  logic [IDX_W-1:0] raddr,
  output link_t            rdata
);

  link_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/fbpa_div.sv
// offset check for free: range compare and restoring divide, one quotient bit a cycle
`timescale 1ns / 1ps
module fbpa_div
  import fbpa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [OFS_W-1:0]  ofs,
  input  logic [SIZE_W-1:0] blk,
  input  logic [CAP_W-1:0]  cap,
  output div_res_t          res
);

  localparam int CNT_W = $clog2(IDX_W);
  localparam int LIM_W = CAP_W + SIZE_W;

  logic             busy;
  logic             fin;
  logic [CNT_W-1:0] cnt;
  logic [OFS_W-1:0] rem;
  logic [OFS_W-1:0] ofs_q;
  logic [SIZE_W-1:0] blk_q;
  logic [LIM_W-1:0] limit;
  logic [IDX_W-1:0] quot;
  logic [OFS_W-1:0] shifted;
  logic             fits;

  // in range means quotient < SLOTS, so IDX_W steps suffice
  assign shifted = OFS_W'(blk_q) << cnt;
  assign fits    = rem >= shifted;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
    end else begin
      fin <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(IDX_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= ofs;
      ofs_q <= ofs;
      blk_q <= blk;
      limit <= LIM_W'(cap) * LIM_W'(blk);
      quot  <= '0;
    end else if (busy) begin
      quot[cnt] <= fits;
      if (fits) begin
        rem <= rem - shifted;
      end
    end
  end

  always_comb begin
    res.done = fin;
    res.bad  = (LIM_W'(ofs_q) >= limit) || (rem != '0);
    res.quot = quot;
  end

endmodule

>>> rtl/fixed_block_pool_allocator_core.sv
// top level: request sequencer, free-list head and result register
`timescale 1ns / 1ps
// Fixed-size block pool allocator.
// Request channel req/req_valid/req_stall carries one request (alloc, zeroed
// alloc, free, reset pool); response channel rsp/rsp_valid/rsp_stall returns
// exactly one response per request, in order.
// Configuration: cfg_we with cfg_index 0 writes capacity, 1 writes member
// size; write only while no request is outstanding.
// One request is worked on at a time. req_stall is high from acceptance until
// the response is loaded into the output register.
// Steps per request, acceptance to rsp_valid:
//   alloc from never-used blocks, reset pool: result reg, then output reg
//   alloc from the freed list: one link memory read, result reg, output reg
//   free: range multiply, 8 restoring divide steps, link write, output reg
// A finished response waits in the output register while the next request
// is accepted; with rsp_stall high the block finishes at most one more
// request and then holds it until the output register frees up.
// Reset (rst, synchronous) empties the freed list, restarts the never-used
// blocks at 0 and loads capacity 256 and member size 8. The link memory
// needs no clearing: an entry is always written by a free before it is read.
module fixed_block_pool_allocator_core
  import fbpa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  req_t                 req,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output rsp_t                 rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_POP  = 4'b0010,
    S_DIV  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t            state;
  logic [CAP_W-1:0]  capacity;
  logic [SIZE_W-1:0] member_size;
  logic [CAP_W-1:0]  untouched_next;
  logic [IDX_W-1:0]  freed_head;
  logic              freed_valid;
  logic              zeroed;
  rsp_t              res;

  logic [CAP_W-1:0]  cap_eff;
  logic [SIZE_W-1:0] blk;
  logic              accept;
  logic              out_free;
  logic [IDX_W-1:0]  mul_idx;
  logic [OFS_W-1:0]  mul_prod;
  logic              div_start;
  div_res_t          div_res;
  logic              ram_we;
  logic              ram_re;
  link_t             ram_wdata;
  link_t             ram_rdata;

  assign cap_eff   = eff_capacity(capacity);
  assign blk       = block_bytes(member_size);
  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;

  // one multiplier shared by both alloc paths
  assign mul_idx  = (state == S_POP) ? freed_head : untouched_next[IDX_W-1:0];
  assign mul_prod = OFS_W'(mul_idx) * OFS_W'(blk);

  assign div_start = accept && (req.req_type == REQ_FREE);
  assign ram_re    = accept && freed_valid &&
                     (req.req_type == REQ_ALLOC || req.req_type == REQ_ZALLOC);
  assign ram_we    = (state == S_DIV) && div_res.done && !div_res.bad;
  assign ram_wdata = '{valid: freed_valid, head: freed_head};

  fbpa_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .ofs   (req.slot_offset),
    .blk   (blk),
    .cap   (cap_eff),
    .res   (div_res)
  );

  fbpa_link_ram u_link (
    .clk   (clk),
    .we    (ram_we),
    .waddr (div_res.quot),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (freed_head),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity    <= CAP_W'(SLOTS);
      member_size <= SIZE_W'(MIN_BLOCK_BYTES);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CAPACITY:    capacity    <= cfg_data[CAP_W-1:0];
        CFG_MEMBER_SIZE: member_size <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      untouched_next <= '0;
      freed_valid    <= 1'b0;
      freed_head     <= '0;
      rsp_valid      <= 1'b0;
    end else begin
      if (state == S_OUT && out_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            zeroed <= (req.req_type == REQ_ZALLOC);
            unique case (req.req_type) inside
              REQ_ALLOC, REQ_ZALLOC: begin
                if (freed_valid) begin
                  state <= S_POP;
                end else if (untouched_next < cap_eff) begin
                  res            <= '{status: ST_OK, block_offset: mul_prod,
                                      clear_slot: (req.req_type == REQ_ZALLOC)};
                  untouched_next <= untouched_next + 1'b1;
                  state          <= S_OUT;
                end else begin
                  res   <= '{status: ST_EXHAUSTED, block_offset: '0, clear_slot: 1'b0};
                  state <= S_OUT;
                end
              end
              REQ_FREE: begin
                state <= S_DIV;
              end
              default: begin
                res            <= '{status: ST_OK, block_offset: '0, clear_slot: 1'b0};
                untouched_next <= '0;
                freed_valid    <= 1'b0;
                state          <= S_OUT;
              end
            endcase
          end
        end
        S_POP: begin
          // link read issued at acceptance, data ready now
          res         <= '{status: ST_OK, block_offset: mul_prod, clear_slot: zeroed};
          freed_head  <= ram_rdata.head;
          freed_valid <= ram_rdata.valid;
          state       <= S_OUT;
        end
        S_DIV: begin
          if (div_res.done) begin
            if (div_res.bad) begin
              res <= '{status: ST_INVALID, block_offset: '0, clear_slot: 1'b0};
            end else begin
              res         <= '{status: ST_OK, block_offset: '0, clear_slot: 1'b0};
              freed_head  <= div_res.quot;
              freed_valid <= 1'b1;
            end
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            rsp   <= res;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/fbpa_checker.sv
// port-level checks for the block pool allocator, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fbpa_port_checker
  import fbpa_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 req_valid,
  input logic                 req_stall,
  input logic                 rsp_valid,
  input logic                 rsp_stall,
  input rsp_t                 rsp
);

  logic req_acc;
  logic rsp_fail;

  assign req_acc  = req_valid && !req_stall;
  assign rsp_fail = rsp_valid && (rsp.status != ST_OK);

  // a stalled response holds
  `ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))
  // one request at a time: busy right after acceptance
  `ASSERT_NXT(a_busy_after_req, req_acc, req_stall)
  // a new response only comes out of a busy sequencer
  `ASSERT_IMP(a_rsp_from_busy, $rose(rsp_valid), $past(req_stall))
  // failed requests carry no block and no clear
  `ASSERT_IMP(a_fail_empty, rsp_fail, rsp.block_offset == '0 && !rsp.clear_slot)

endmodule

bind fixed_block_pool_allocator_core fbpa_port_checker u_fbpa_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

>>> tb/sv/fbpa_checker.sv
// request/response checker for the block pool allocator: predicts every answer and compares
`timescale 1ns / 1ps
module fbpa_checker
  import fbpa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  input  logic                 req_stall,
  input  req_t                 req,
  input  logic                 rsp_valid,
  input  logic                 rsp_stall,
  input  rsp_t                 rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   mismatches,
  output int                   answers_open,
  output int                   answers_checked,
  output int                   exhausted_seen,
  output int                   invalid_seen
);

  typedef struct {
    req_t r;
    rsp_t a;
  } due_t;

  // shadow of the pool: registers, never-used cursor and freed list
  logic [CAP_W-1:0]  cap_reg;
  logic [SIZE_W-1:0] size_reg;
  int unsigned       untouched_next;
  logic [IDX_W-1:0]  freed_head;
  logic              freed_valid;
  link_t             links [SLOTS];

  due_t answers_due [$];
  int   fail_cnt;
  int   check_cnt;
  int   exh_cnt;
  int   inv_cnt;

  function automatic rsp_t pool_answer(input req_t r);
    int unsigned cap_eff;
    int unsigned blk;
    int unsigned idx;
    int unsigned ofs;
    bit          got;
    rsp_t        a;
    a   = '0;
    got = 1'b0;
    idx = 0;
    blk = size_reg;
    if (blk < MIN_BLOCK_BYTES) blk = MIN_BLOCK_BYTES;
    if (blk > MAX_BLOCK_BYTES) blk = MAX_BLOCK_BYTES;
    cap_eff = cap_reg;
    if (cap_eff > SLOTS) cap_eff = SLOTS;
    case (r.req_type) inside
      REQ_ALLOC, REQ_ZALLOC: begin
        // freed blocks first (lifo), then the lowest never-used one
        if (freed_valid) begin
          idx         = freed_head;
          freed_valid = links[idx].valid;
          freed_head  = links[idx].head;
          got         = 1'b1;
        end else if (untouched_next < cap_eff) begin
          idx            = untouched_next;
          untouched_next = untouched_next + 1;
          got            = 1'b1;
        end
        if (got) begin
          a.block_offset = OFS_W'(idx * blk);
          a.clear_slot   = (r.req_type == REQ_ZALLOC);
        end else begin
          a.status = ST_EXHAUSTED;
        end
      end
      REQ_FREE: begin
        ofs = r.slot_offset;
        if (ofs >= cap_eff * blk || ofs % blk != 0) begin
          a.status = ST_INVALID;
        end else begin
          idx        = (ofs / blk) % SLOTS;
          links[idx] = '{valid: freed_valid, head: freed_head};
          freed_head  = IDX_W'(idx);
          freed_valid = 1'b1;
        end
      end
      default: begin
        untouched_next = 0;
        freed_head     = '0;
        freed_valid    = 1'b0;
      end
    endcase
    return a;
  endfunction

  always @(posedge clk) begin
    due_t e;
    if (rst) begin
      cap_reg        = CAP_W'(256);
      size_reg       = SIZE_W'(8);
      untouched_next = 0;
      freed_head     = '0;
      freed_valid    = 1'b0;
      answers_due.delete();
    end else begin
      // check the response before queueing a request taken at the same edge
      if (rsp_valid && !rsp_stall) begin
        check_cnt++;
        if (rsp.status == ST_EXHAUSTED) exh_cnt++;
        if (rsp.status == ST_INVALID) inv_cnt++;
        if (answers_due.size() == 0) begin
          if (fail_cnt < 10)
            $display("%t: response with no request outstanding: status %0d ofs %h clr %b",
                     $realtime, rsp.status, rsp.block_offset, rsp.clear_slot);
          fail_cnt++;
        end else begin
          e = answers_due.pop_front();
          if (rsp.status !== e.a.status || rsp.block_offset !== e.a.block_offset ||
              rsp.clear_slot !== e.a.clear_slot) begin
            if (fail_cnt < 10) begin
              $display("%t: mismatch for req %0d ofs %h: expected status %0d ofs %h clr %b",
                       $realtime, e.r.req_type, e.r.slot_offset, e.a.status,
                       e.a.block_offset, e.a.clear_slot);
              $display("%t:   got status %0d ofs %h clr %b", $realtime, rsp.status,
                       rsp.block_offset, rsp.clear_slot);
            end
            fail_cnt++;
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_CAPACITY) cap_reg = cfg_data[CAP_W-1:0];
        else if (cfg_index == CFG_MEMBER_SIZE) size_reg = cfg_data[SIZE_W-1:0];
      end
      if (req_valid && !req_stall) begin
        e.r = req;
        e.a = pool_answer(req);
        answers_due.push_back(e);
      end
    end
    mismatches      <= fail_cnt;
    answers_open    <= answers_due.size();
    answers_checked <= check_cnt;
    exhausted_seen  <= exh_cnt;
    invalid_seen    <= inv_cnt;
  end

endmodule

>>> tb/sv/tb_top.sv
// testbench top for the block pool allocator: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module tb_top;
  import fbpa_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 req_valid = 1'b0;
  logic                 req_stall;
  req_t                 req = '0;
  logic                 rsp_valid;
  logic                 rsp_stall = 1'b0;
  rsp_t                 rsp;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_CAPACITY;
  logic [CFG_W-1:0]     cfg_data = '0;

  int mismatches;
  int answers_open;
  int answers_checked;
  int exhausted_seen;
  int invalid_seen;

  int cur_cap = 256;
  int cur_size = 8;
  int sent = 0;
  int settings = 0;
  bit sender_calm = 1'b0;

  always #10 clk = ~clk;

  fixed_block_pool_allocator_core dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  fbpa_checker chk (
    .clk             (clk),
    .rst             (rst),
    .req_valid       (req_valid),
    .req_stall       (req_stall),
    .req             (req),
    .rsp_valid       (rsp_valid),
    .rsp_stall       (rsp_stall),
    .rsp             (rsp),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .answers_open    (answers_open),
    .answers_checked (answers_checked),
    .exhausted_seen  (exhausted_seen),
    .invalid_seen    (invalid_seen)
  );

  function automatic req_t mk(input logic [1:0] kind, input int unsigned ofs);
    req_t r;
    r.req_type    = kind;
    r.slot_offset = OFS_W'(ofs);
    return r;
  endfunction

  // mostly alloc/free of block-aligned offsets, some bad frees and pool resets
  function automatic req_t random_req();
    int unsigned eff;
    int unsigned blk;
    int          pick;
    req_t        r;
    eff = (cur_cap > SLOTS) ? SLOTS : cur_cap;
    blk = cur_size;
    if (blk < MIN_BLOCK_BYTES) blk = MIN_BLOCK_BYTES;
    if (blk > MAX_BLOCK_BYTES) blk = MAX_BLOCK_BYTES;
    r.slot_offset = OFS_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      r.req_type = REQ_ALLOC;
    end else if (pick < 50) begin
      r.req_type = REQ_ZALLOC;
    end else if (pick < 97) begin
      r.req_type = REQ_FREE;
      if (pick < 82 && eff > 0)
        r.slot_offset = OFS_W'($urandom_range(0, eff - 1) * blk);
      else if (pick < 89 && eff > 0)
        r.slot_offset = OFS_W'($urandom_range(0, eff - 1) * blk + $urandom_range(1, blk - 1));
      else if (pick < 92)
        r.slot_offset = OFS_W'(eff * blk + $urandom_range(0, 2) * blk);
    end else begin
      r.req_type = REQ_RESET;
    end
    return r;
  endfunction

  task automatic send(input req_t r);
    int gap;
    if (sent % 64 == 0) sender_calm = ($urandom_range(0, 3) == 0);
    gap = sender_calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sent++;
  endtask

  // hold off new requests until every answer is back
  task automatic wait_quiet();
    req_valid <= 1'b0;
    @(posedge clk);
    while (answers_open != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_pool(input int cap, input int size);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CAPACITY;
    cfg_data  <= CFG_W'(cap);
    @(posedge clk);
    cfg_index <= CFG_MEMBER_SIZE;
    cfg_data  <= CFG_W'(size);
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_cap  = cap;
    cur_size = size;
    settings++;
  endtask

  // response side: random stall before taking each response
  initial begin : rsp_side
    int w;
    int n;
    bit calm;
    n    = 0;
    calm = 1'b0;
    forever begin
      if (n % 50 == 0) calm = ($urandom_range(0, 3) == 0);
      w = calm ? 0 : $urandom_range(0, 11);
      if (w > 0) begin
        rsp_stall <= 1'b1;
        repeat (w) @(posedge clk);
        rsp_stall <= 1'b0;
      end
      @(posedge clk);
      while (rsp_valid !== 1'b1) @(posedge clk);
      n++;
    end
  end

  initial begin : watchdog
    #(10_000_000);
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    int caps [11];
    int sizes [11];
    int ph;
    int i;
    caps  = '{256, 1, 2, 511, 5, 0, 17, 256, 300, 64, 3};
    sizes = '{8, 1, 4096, 8191, 9, 0, 100, 4096, 4097, 7, 13};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // small pool, member size below the minimum
    set_pool(3, 0);
    send(mk(REQ_ALLOC, 0));
    send(mk(REQ_ZALLOC, 20'hFFFFF));
    send(mk(REQ_ALLOC, 0));
    send(mk(REQ_ALLOC, 0));           // exhausted
    send(mk(REQ_ZALLOC, 0));          // exhausted, no clear
    send(mk(REQ_FREE, 8));
    send(mk(REQ_FREE, 4));            // not on a block boundary
    send(mk(REQ_FREE, 24));           // just past the pool
    send(mk(REQ_FREE, 20'hFFFFF));
    send(mk(REQ_FREE, 16));
    send(mk(REQ_FREE, 16));           // double free goes through
    send(mk(REQ_ALLOC, 0));
    send(mk(REQ_ZALLOC, 0));
    send(mk(REQ_ALLOC, 0));
    send(mk(REQ_ALLOC, 0));
    send(mk(REQ_RESET, 20'hAAAAA));
    send(mk(REQ_ALLOC, 0));
    send(mk(REQ_FREE, 0));
    wait_quiet();
    // shrink the pool and raise the block size with a block still on the freed list
    set_pool(1, 4096);
    send(mk(REQ_ALLOC, 0));
    send(mk(REQ_ALLOC, 0));
    send(mk(REQ_FREE, 4096));
    send(mk(REQ_FREE, 0));
    wait_quiet();
    // empty pool, oversized member
    set_pool(0, 8191);
    send(mk(REQ_ZALLOC, 0));
    send(mk(REQ_ALLOC, 0));
    send(mk(REQ_FREE, 0));
    wait_quiet();
    // capacity above the slot count saturates
    set_pool(511, 1);
    send(mk(REQ_FREE, 2040));
    send(mk(REQ_FREE, 2048));
    send(mk(REQ_RESET, 0));
    send(mk(REQ_ALLOC, 0));
    wait_quiet();

    for (ph = 0; ph < 14; ph++) begin
      if (ph < 11) set_pool(caps[ph], sizes[ph]);
      else set_pool($urandom_range(0, 511), $urandom_range(0, 8191));
      for (i = 0; i < 120; i++) begin
        if (i == 60) wait_quiet();
        send(random_req());
      end
      wait_quiet();
    end

    repeat (12) @(posedge clk);
    $display("summary: %0d responses checked across %0d pool settings",
             answers_checked, settings);
    $display("summary: %0d exhausted and %0d invalid-argument answers among them",
             exhausted_seen, invalid_seen);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
